@@ sv/dsm_pkg.sv @@
// ----------------------------------------------------------------------------
// dsm_pkg
// Types and constants for the decimal schoolbook multiplier.
// ----------------------------------------------------------------------------
package dsm_pkg;

	localparam int DIGIT_W = 4;
	localparam int MAX_DIGITS_DEF = 32;
	localparam int RADIX = 10;

	// floor(x / 10) == (x * DIV10_MUL) >> DIV10_SHIFT for x < 16384
	localparam int DIV10_MUL = 6554;
	localparam int DIV10_MUL_W = 13;
	localparam int DIV10_SHIFT = 16;

	typedef struct packed {
		logic               start_new;
		logic [DIGIT_W-1:0] digit_a;
		logic [DIGIT_W-1:0] digit_b;
	} operand_t;

	typedef struct packed {
		logic [DIGIT_W-1:0] product_digit;
		logic               bad_digit;
		logic               too_long;
	} product_t;

endpackage

@@ sv/decimal_schoolbook_multiplier.sv @@
// ----------------------------------------------------------------------------
// decimal_schoolbook_multiplier
// Streaming decimal long multiplier, digits least significant first.
// ----------------------------------------------------------------------------
// Each operand transaction carries one digit of each factor and yields one
// product digit. Digits are kept in two single-port digit memories. The column
// for position p holds T = min(p + 1, 2*MAX_DIGITS - 1 - p) digit products
// (none from position 2*MAX_DIGITS - 1 on); one product is read from the
// memories and accumulated per cycle, and an operand occupies the block
// through accept, the T reads plus a drain step, the divide by ten and the
// result load. A result waiting in the output register does not stop the
// next operand being taken. Feed zero pairs after the last digits to flush
// the upper product digits; start_new restarts at position zero with no carry.
module decimal_schoolbook_multiplier
	#(
		parameter int MAX_DIGITS = dsm_pkg::MAX_DIGITS_DEF
	)
	(
		input  logic              clk,
		input  logic              arst_n,
		input  logic              operand_valid,
		output logic              operand_ready,
		input  dsm_pkg::operand_t operand,
		output logic              product_valid,
		input  logic              product_ready,
		output dsm_pkg::product_t product
	);

	import dsm_pkg::*;

	localparam int IDX_W   = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int POS_W   = $clog2(2 * MAX_DIGITS + 1);
	localparam int CNT_W   = $clog2(MAX_DIGITS + 1);
	localparam int CARRY_W = $clog2(9 * MAX_DIGITS + 1);
	localparam int SUM_W   = $clog2(90 * MAX_DIGITS + 1);
	localparam int PROD_W  = SUM_W + DIV10_MUL_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [DIGIT_W-1:0] mem_a [MAX_DIGITS];
	logic [DIGIT_W-1:0] mem_b [MAX_DIGITS];
	logic [DIGIT_W-1:0] a_rd_s1;
	logic [DIGIT_W-1:0] b_rd_s1;
	logic               rd_v_s1;

	logic [POS_W-1:0]   pos_q;
	logic [CARRY_W-1:0] carry_q;
	logic [SUM_W-1:0]   acc_q;
	logic [CARRY_W-1:0] quo_q;
	logic [IDX_W-1:0]   j_q;
	logic [IDX_W-1:0]   k_q;
	logic [CNT_W-1:0]   rem_q;
	logic               bad_q;
	logic               long_q;

	logic               accept;
	logic               rd_en;
	logic               res_load;
	logic [POS_W-1:0]   p_eff;
	logic [CARRY_W-1:0] carry_eff;
	logic [DIGIT_W-1:0] da;
	logic [DIGIT_W-1:0] db;
	logic               bad;
	logic               in_range;
	logic               longer;
	logic [IDX_W-1:0]   j0;
	logic [IDX_W-1:0]   k0;
	logic [CNT_W-1:0]   cnt0;
	logic [PROD_W-1:0]  qprod;
	logic [SUM_W-1:0]   digit_sum;

	assign operand_ready = (state_q == ST_IDLE);
	assign accept        = operand_valid && operand_ready;
	assign rd_en         = (state_q == ST_RUN) && (rem_q != '0);
	assign res_load      = (state_q == ST_DONE) && (!product_valid || product_ready);

	always_comb begin
		p_eff     = operand.start_new ? '0 : pos_q;
		carry_eff = operand.start_new ? '0 : carry_q;
		da        = operand.digit_a;
		db        = operand.digit_b;
		bad       = 1'b0;
		if (operand.digit_a > DIGIT_W'(RADIX - 1)) begin
			da  = '0;
			bad = 1'b1;
		end
		if (operand.digit_b > DIGIT_W'(RADIX - 1)) begin
			db  = '0;
			bad = 1'b1;
		end
		in_range = (p_eff < POS_W'(MAX_DIGITS));
		longer   = !in_range && ((da != '0) || (db != '0));
		if (in_range) begin
			j0   = '0;
			k0   = p_eff[IDX_W-1:0];
			cnt0 = CNT_W'(p_eff) + CNT_W'(1);
		end else begin
			j0 = IDX_W'(p_eff - POS_W'(MAX_DIGITS - 1));
			k0 = IDX_W'(MAX_DIGITS - 1);
			if (p_eff < POS_W'(2 * MAX_DIGITS))
				cnt0 = CNT_W'(POS_W'(2 * MAX_DIGITS - 1) - p_eff);
			else
				cnt0 = '0;
		end
	end

	assign qprod     = PROD_W'(acc_q) * PROD_W'(DIV10_MUL);
	assign digit_sum = acc_q - SUM_W'(quo_q) * SUM_W'(RADIX);

	// digit memories: written at accept, read one column term per cycle
	always_ff @(posedge clk) begin
		if (accept && in_range) begin
			mem_a[p_eff[IDX_W-1:0]] <= da;
			mem_b[p_eff[IDX_W-1:0]] <= db;
		end
		if (rd_en) begin
			a_rd_s1 <= mem_a[j_q];
			b_rd_s1 <= mem_b[k_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			pos_q         <= '0;
			carry_q       <= '0;
			acc_q         <= '0;
			quo_q         <= '0;
			j_q           <= '0;
			k_q           <= '0;
			rem_q         <= '0;
			bad_q         <= 1'b0;
			long_q        <= 1'b0;
			rd_v_s1       <= 1'b0;
			product_valid <= 1'b0;
			product       <= '0;
		end else begin
			rd_v_s1 <= rd_en;
			if (rd_v_s1)
				acc_q <= acc_q + SUM_W'(8'(a_rd_s1) * 8'(b_rd_s1));
			if (res_load)
				product_valid <= 1'b1;
			else if (product_ready)
				product_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (operand_valid) begin
						pos_q   <= p_eff;
						acc_q   <= SUM_W'(carry_eff);
						j_q     <= j0;
						k_q     <= k0;
						rem_q   <= cnt0;
						bad_q   <= bad;
						long_q  <= longer;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (rd_en) begin
						j_q   <= j_q + IDX_W'(1);
						k_q   <= k_q - IDX_W'(1);
						rem_q <= rem_q - CNT_W'(1);
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					quo_q   <= CARRY_W'(qprod >> DIV10_SHIFT);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_load) begin
						product.product_digit <= digit_sum[DIGIT_W-1:0];
						product.bad_digit     <= bad_q;
						product.too_long      <= long_q;
						carry_q               <= quo_q;
						if (pos_q < POS_W'(2 * MAX_DIGITS))
							pos_q <= pos_q + POS_W'(1);
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_div_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q == '0) && !rd_v_s1)
		else $error("column terms still pending at divide");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (digit_sum < SUM_W'(RADIX)))
		else $error("column remainder out of range");

	a_carry_bound: assert property (@(posedge clk) disable iff (!arst_n)
		carry_q <= CARRY_W'(9 * MAX_DIGITS))
		else $error("column carry above bound");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(product_valid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside result load");
`endif

endmodule

@@ dv/tb_decimal_schoolbook_multiplier.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_decimal_schoolbook_multiplier
// Self-checking bench for the streaming decimal long multiplier.
// ----------------------------------------------------------------------------
// Digit pairs are fed least significant first. A column model kept in the
// bench predicts every product digit with its flags. Each result is checked
// against the oldest prediction. Covered: directed small products, bad
// digits, operands past the digit limit, position saturation, a long output
// hold-off and a full drain. These are followed by random products, noise and
// broken sequences under random sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_decimal_schoolbook_multiplier;

	import dsm_pkg::*;

	localparam int NDIG        = MAX_DIGITS_DEF;
	localparam int ITEMS_TOTAL = 1750;
	localparam int SETTLE      = 2 * NDIG + 16;
	localparam int IDLE_LIMIT  = 5000;
	localparam int MAX_REPORTS = 100;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     operand_valid = 1'b0;
	logic     operand_ready;
	operand_t operand = '0;
	logic     product_valid;
	logic     product_ready = 1'b0;
	product_t product;

	logic [DIGIT_W-1:0] factor_a_digits [NDIG];
	logic [DIGIT_W-1:0] factor_b_digits [NDIG];
	int                 col_pos = 0;
	int                 col_carry = 0;

	product_t expected_products [$];
	int       mismatches = 0;
	int       products_seen = 0;
	int       items_sent = 0;
	int       burst_left = 0;
	int       hold_left = 0;
	int       rx_cycle = 0;
	int       rx_mode = 0;

	decimal_schoolbook_multiplier #(.MAX_DIGITS(NDIG)) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.operand_valid (operand_valid),
		.operand_ready (operand_ready),
		.operand       (operand),
		.product_valid (product_valid),
		.product_ready (product_ready),
		.product       (product)
	);

	always #2 clk = ~clk;

	// column sum of the stored digits plus carry in
	function automatic product_t predict_column(operand_t op);
		product_t           r;
		logic [DIGIT_W-1:0] da;
		logic [DIGIT_W-1:0] db;
		int                 sum;
		int                 lo;
		int                 hi;
		int                 j;
		r = '0;
		if (op.start_new) begin
			col_pos = 0;
			col_carry = 0;
		end
		da = op.digit_a;
		db = op.digit_b;
		if (da > 9) begin
			da = '0;
			r.bad_digit = 1'b1;
		end
		if (db > 9) begin
			db = '0;
			r.bad_digit = 1'b1;
		end
		if (col_pos < NDIG) begin
			factor_a_digits[col_pos] = da;
			factor_b_digits[col_pos] = db;
		end else if (da != 0 || db != 0) begin
			r.too_long = 1'b1;
		end
		sum = col_carry;
		lo = (col_pos >= NDIG) ? col_pos - NDIG + 1 : 0;
		hi = (col_pos < NDIG) ? col_pos : NDIG - 1;
		for (j = lo; j <= hi; j++)
			sum += int'(factor_a_digits[j]) * int'(factor_b_digits[col_pos - j]);
		r.product_digit = DIGIT_W'(sum % RADIX);
		col_carry = sum / RADIX;
		if (col_pos < 2 * NDIG)
			col_pos++;
		return r;
	endfunction

	function automatic logic [DIGIT_W-1:0] random_digit();
		if ($urandom_range(0, 19) == 0)
			return DIGIT_W'($urandom_range(10, 15));
		return DIGIT_W'($urandom_range(0, 9));
	endfunction

	task automatic report_mismatch(string msg);
		if (mismatches < MAX_REPORTS)
			$display("ERROR @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// valid stays high between back-to-back transactions
	task automatic send_digits(bit s, logic [DIGIT_W-1:0] a, logic [DIGIT_W-1:0] b);
		operand_t op;
		op.start_new = s;
		op.digit_a = a;
		op.digit_b = b;
		operand <= op;
		operand_valid <= 1'b1;
		@(posedge clk);
		while (!operand_ready)
			@(posedge clk);
		expected_products.push_back(predict_column(op));
		items_sent++;
	endtask

	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			if ($urandom_range(0, 3) != 0) begin
				operand_valid <= 1'b0;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 12);
		end
	endtask

	task automatic wait_products_drained();
		operand_valid <= 1'b0;
		while (expected_products.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic test_directed_digits();
		send_digits(1, 0, 0);
		send_digits(1, 9, 9);
		send_digits(0, 0, 0);
		send_digits(0, 0, 0);
		send_digits(1, 15, 15);
		send_digits(0, 10, 3);
		send_digits(1, 9, 12);
		send_digits(0, 3, 4);
		send_digits(1, 9, 9);
		send_digits(0, 9, 9);
		send_digits(0, 0, 0);
		send_digits(0, 0, 0);
		send_digits(1, 2, 4);
		send_digits(0, 1, 3);
		send_digits(0, 0, 0);
		send_digits(0, 0, 0);
		// no start flag: carries on as one long product
		send_digits(0, 7, 8);
		send_digits(0, 0, 0);
	endtask

	// full-length nines, digits past the limit, then run into saturation
	task automatic test_digit_limit();
		int i;
		for (i = 0; i < NDIG; i++)
			send_digits(i == 0, 9, 9);
		send_digits(0, 9, 0);
		send_digits(0, 15, 0);
		send_digits(0, 12, 7);
		send_digits(0, 0, 1);
		for (i = 0; i < NDIG + 8; i++)
			send_digits(0, 0, 0);
		send_digits(0, 5, 5);
		send_digits(1, 4, 6);
		send_digits(0, 0, 0);
	endtask

	task automatic test_output_hold_off();
		int i;
		hold_left = 300;
		for (i = 0; i < 40; i++)
			send_digits(i == 0, random_digit(), random_digit());
		wait_products_drained();
	endtask

	task automatic test_drain_pause();
		send_digits(1, 6, 7);
		send_digits(0, 5, 8);
		send_digits(0, 0, 0);
		send_digits(0, 0, 0);
		wait_products_drained();
		send_digits(1, 3, 3);
		send_digits(0, 0, 0);
	endtask

	task automatic random_product();
		int n;
		int flush;
		int r;
		int i;
		r = $urandom_range(0, 99);
		if (r < 80)
			n = $urandom_range(1, 6);
		else if (r < 95)
			n = $urandom_range(7, 20);
		else if (r < 99)
			n = $urandom_range(21, NDIG);
		else
			n = $urandom_range(NDIG + 1, NDIG + 8);
		r = $urandom_range(0, 9);
		if (r < 7)
			flush = n;
		else if (r < 9)
			flush = $urandom_range(0, n - 1);
		else
			flush = n + $urandom_range(1, 40);
		for (i = 0; i < n; i++) begin
			send_digits(i == 0 && $urandom_range(0, 9) != 0, random_digit(), random_digit());
			pace();
		end
		for (i = 0; i < flush; i++) begin
			send_digits(0, 0, 0);
			pace();
		end
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 5)) begin
				send_digits(1'($urandom_range(0, 1)), DIGIT_W'($urandom_range(0, 15)),
					DIGIT_W'($urandom_range(0, 15)));
				pace();
			end
		end
	endtask

	task automatic test_random_products();
		while (items_sent < ITEMS_TOTAL) begin
			random_product();
			if ($urandom_range(0, 24) == 0)
				wait_products_drained();
		end
	endtask

	// receiver stall pattern, with a counted hold-off on request
	always @(posedge clk) begin
		rx_cycle++;
		if (rx_cycle % 128 == 0)
			rx_mode = $urandom_range(0, 2);
		if (hold_left > 0) begin
			hold_left--;
			product_ready <= 1'b0;
		end else begin
			case (rx_mode)
				0: begin
					product_ready <= 1'b1;
				end
				1: begin
					product_ready <= ($urandom_range(0, 2) != 0);
				end
				default: begin
					product_ready <= (rx_cycle % 9) >= 4;
				end
			endcase
		end
	end

	always @(posedge clk) begin : check_products
		product_t want;
		if (product_valid && product_ready) begin
			products_seen++;
			if (expected_products.size() == 0) begin
				report_mismatch($sformatf("product %0d: transaction with none expected",
					products_seen));
			end else begin
				want = expected_products.pop_front();
				if (product.product_digit !== want.product_digit)
					report_mismatch($sformatf("product %0d: digit %0d, expected %0d",
						products_seen, product.product_digit, want.product_digit));
				if (product.bad_digit !== want.bad_digit)
					report_mismatch($sformatf("product %0d: bad_digit %0b, expected %0b",
						products_seen, product.bad_digit, want.bad_digit));
				if (product.too_long !== want.too_long)
					report_mismatch($sformatf("product %0d: too_long %0b, expected %0b",
						products_seen, product.too_long, want.too_long));
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((operand_valid && operand_ready) || (product_valid && product_ready))
				idle = 0;
			else
				idle++;
		end
		$display("** decimal_schoolbook_multiplier: FAILED **");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_digits();
		test_digit_limit();
		test_output_hold_off();
		test_drain_pause();
		test_random_products();
		wait_products_drained();
		if (mismatches == 0 && expected_products.size() == 0)
			$display("** decimal_schoolbook_multiplier: PASSED **");
		else
			$display("** decimal_schoolbook_multiplier: FAILED **");
		$finish;
	end

endmodule
